// ===== design/sasa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solvation area overlap update package
// Shared widths, constants, the atom record type and a small helper function.
// ----------------------------------------------------------------------------
package sasa_pkg;

	localparam int ATOMS   = 1024;
	localparam int IDX_W   = $clog2(ATOMS);
	localparam int CRD_W   = 24;
	localparam int RAD_W   = 16;
	localparam int PRS_W   = 24;
	localparam int WPA_W   = 32;
	localparam int AREA_W  = 17;
	localparam int PROBE_W = 14;
	localparam int FAC_W   = 16;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int DIV_Q_W   = 32;
	localparam int DIV_DEN_W = 40;
	localparam int SQ_IN_W   = 52;
	localparam int SQ_OUT_W  = SQ_IN_W / 2;

	localparam logic [17:0]       PI_Q16     = 18'd205887;
	localparam logic [19:0]       FOURPI_Q16 = 20'd823550;
	localparam logic [AREA_W-1:0] ONE_Q16    = 17'd65536;
	localparam logic [24:0]       RATIO_SAT  = 25'd16777216;

	localparam logic [PROBE_W-1:0] PROBE_RST  = 14'd2458;
	localparam logic [FAC_W-1:0]   FBOND_RST  = 16'd58163;
	localparam logic [FAC_W-1:0]   FANGLE_RST = 16'd23043;
	localparam logic [FAC_W-1:0]   FFAR_RST   = 16'd20683;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_BONDED = 2'd1;
	localparam logic [1:0] OP_ANGLE  = 2'd2;
	localparam logic [1:0] OP_FAR    = 2'd3;

	localparam logic [1:0] REG_PROBE  = 2'd0;
	localparam logic [1:0] REG_FBOND  = 2'd1;
	localparam logic [1:0] REG_FANGLE = 2'd2;
	localparam logic [1:0] REG_FFAR   = 2'd3;

	typedef struct packed {
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] z;
		logic [RAD_W-1:0] rad;
		logic [PRS_W-1:0] prs;
		logic [WPA_W-1:0] wpa;
	} atom_rec_t;

	function automatic logic [CRD_W:0] abs_diff(input logic [CRD_W-1:0] p,
		input logic [CRD_W-1:0] q);
		logic [CRD_W:0] d;
		d = {p[CRD_W-1], p} - {q[CRD_W-1], q};
		return d[CRD_W] ? (~d + 1'b1) : d;
	endfunction

endpackage

// ===== design/sasa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Computes (rem0 * 2^32 + num) / den one quotient bit per cycle; rem0 < den.
// ----------------------------------------------------------------------------
module sasa_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sasa_pkg::DIV_DEN_W-1:0] rem0,
	input  logic [sasa_pkg::DIV_Q_W-1:0]   num,
	input  logic [sasa_pkg::DIV_DEN_W-1:0] den,
	output logic                           done,
	output logic [sasa_pkg::DIV_Q_W-1:0]   quot
);
	import sasa_pkg::*;

	localparam int CNT_W = $clog2(DIV_Q_W);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_Q_W-1:0]   num_q;
	logic [DIV_Q_W-1:0]   quot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, num_q[DIV_Q_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_Q_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem0;
			den_q <= den;
			num_q <= num;
		end else if (run_q) begin
			num_q  <= {num_q[DIV_Q_W-2:0], 1'b0};
			rem_q  <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			quot_q <= {quot_q[DIV_Q_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== design/sasa_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root
// Floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sasa_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sasa_pkg::SQ_IN_W-1:0]  radicand,
	output logic                          done,
	output logic [sasa_pkg::SQ_OUT_W-1:0] root
);
	import sasa_pkg::*;

	localparam int CNT_W = $clog2(SQ_OUT_W);
	localparam int REM_W = SQ_OUT_W + 2;

	logic [SQ_IN_W-1:0]  v_q;
	logic [REM_W-1:0]    rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                run_q;
	logic                done_q;
	logic [REM_W+1:0]    r;
	logic [REM_W+1:0]    trial;
	logic                fits;

	assign r     = {rem_q, v_q[SQ_IN_W-1:SQ_IN_W-2]};
	assign trial = (REM_W+2)'({root_q, 2'b01});
	assign fits  = r >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(SQ_OUT_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			v_q    <= {v_q[SQ_IN_W-3:0], 2'b00};
			rem_q  <= fits ? REM_W'(r - trial) : REM_W'(r);
			root_q <= {root_q[SQ_OUT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== design/solvation_area_overlap_update_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solvation area overlap update core
// Per-atom table in block memories; loads atoms and shrinks exposed area
// fractions of overlapping atom pairs in fixed point.
// ----------------------------------------------------------------------------
// A load runs the multiply, surface and write states, and the 32-step divider
// when the weight per area needs it. A pair that does not overlap ends after
// the distance test; one that does runs 26 square root steps, up to 32 divider
// steps and two shrink passes. One item is in flight at a time; busy covers it.
// The result strobe valid is high for one cycle. Reset sets the registers to
// their defaults and idles the control; the atom memories are not cleared.
module solvation_area_overlap_update_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sasa_pkg::ADDR_W-1:0]         paddr,
	input  logic [sasa_pkg::DATA_W-1:0]         pwdata,
	output logic [sasa_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          opcode,
	input  logic [sasa_pkg::IDX_W-1:0]          atom_a,
	input  logic [sasa_pkg::IDX_W-1:0]          atom_b,
	input  logic signed [sasa_pkg::CRD_W-1:0]   coord_x,
	input  logic signed [sasa_pkg::CRD_W-1:0]   coord_y,
	input  logic signed [sasa_pkg::CRD_W-1:0]   coord_z,
	input  logic [sasa_pkg::RAD_W-1:0]          radius,
	input  logic [sasa_pkg::RAD_W-1:0]          weight,
	output logic                                valid,
	output logic [sasa_pkg::AREA_W-1:0]         area_a,
	output logic [sasa_pkg::AREA_W-1:0]         area_b,
	output logic                                overlapped
);
	import sasa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LD_MUL, S_LD_SURF, S_LD_DIV, S_LD_WR,
		S_RD_A, S_RD_B, S_DIFF, S_SUM, S_SQRT, S_QSET, S_QDIV,
		S_SH_PM, S_SH_B, S_SH_PP, S_SH_WR
	} state_t;

	state_t state_q;

	logic [PROBE_W-1:0] probe_q;
	logic [FAC_W-1:0]   fbond_q, fangle_q, ffar_q;

	atom_rec_t          rec_mem [ATOMS];
	logic [AREA_W-1:0]  area_mem [ATOMS];
	atom_rec_t          rec_rd_q;
	logic [AREA_W-1:0]  area_rd_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               rec_we, area_we;
	logic [IDX_W-1:0]   area_waddr;
	logic [AREA_W-1:0]  area_wdata;

	logic [1:0]         op_q;
	logic [IDX_W-1:0]   a_q, b_q;
	logic [CRD_W-1:0]   x_q, y_q, z_q;
	logic [RAD_W-1:0]   rad_q, wt_q;
	logic [33:0]        s2_q;
	logic [34:0]        spi_q;
	logic [PRS_W-1:0]   prs_q;
	logic [WPA_W-1:0]   wpa_q;

	atom_rec_t          rec_a_q, rec_b_q;
	logic [AREA_W-1:0]  fa_q, fb_q;
	logic [49:0]        dx2_q, dy2_q, dz2_q;
	logic [17:0]        ol_q;
	logic [SQ_OUT_W-1:0] d_q;
	logic [17:0]        m_q;
	logic [24:0]        qm_q;
	logic               sel_q;
	logic [24:0]        term_q;
	logic [30:0]        pm_q;
	logic [32:0]        w_q;
	logic [39:0]        bv_q;
	logic [73:0]        prod_q;

	logic               valid_q, ov_q;
	logic [AREA_W-1:0]  area_a_q, area_b_q;

	logic [16:0]        s_sum;
	logic [54:0]        surf_full;
	logic [DIV_DEN_W-1:0] surf;
	logic               wpa_sat;
	logic [CRD_W:0]     dx, dy, dz;
	logic [SQ_IN_W-1:0] d2;
	logic               ovl_hit;
	logic [RAD_W-1:0]   ra, rb;
	logic               qneg;
	logic [31:0]        mag;
	logic [26:0]        qs, term;
	logic               term_pos;
	atom_rec_t          rec_sel;
	logic [FAC_W-1:0]   fac;
	logic [AREA_W-1:0]  frac_sel;
	logic               sh_sat;
	logic [15:0]        c_val;
	logic               sh_upd;
	logic [AREA_W-1:0]  frac_new;
	logic [AREA_W-1:0]  frac_out;
	logic [33:0]        frac_prod;

	logic                 div_start, div_done;
	logic [DIV_DEN_W-1:0] div_rem0, div_den;
	logic [DIV_Q_W-1:0]   div_num, div_quot;
	logic                 sq_start, sq_done;
	logic [SQ_OUT_W-1:0]  sq_root;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q  <= PROBE_RST;
			fbond_q  <= FBOND_RST;
			fangle_q <= FANGLE_RST;
			ffar_q   <= FFAR_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_PROBE:  probe_q  <= pwdata[PROBE_W-1:0];
				REG_FBOND:  fbond_q  <= pwdata[FAC_W-1:0];
				REG_FANGLE: fangle_q <= pwdata[FAC_W-1:0];
				REG_FFAR:   ffar_q   <= pwdata[FAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PROBE:  prdata = DATA_W'(probe_q);
			REG_FBOND:  prdata = DATA_W'(fbond_q);
			REG_FANGLE: prdata = DATA_W'(fangle_q);
			REG_FFAR:   prdata = DATA_W'(ffar_q);
			default:    prdata = '0;
		endcase
	end

	// Atom memories.
	assign rd_addr = (state_q == S_IDLE) ? atom_a : b_q;

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[a_q] <= '{x: x_q, y: y_q, z: z_q, rad: rad_q, prs: prs_q, wpa: wpa_q};
		end
		rec_rd_q <= rec_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (area_we) begin
			area_mem[area_waddr] <= area_wdata;
		end
		area_rd_q <= area_mem[rd_addr];
	end

	// Load arithmetic.
	assign s_sum     = 17'(rad_q) + 17'(probe_q);
	assign surf_full = 55'(s2_q) * 55'(FOURPI_Q16) + 55'd32768;
	assign surf      = DIV_DEN_W'(surf_full[54:16]);
	assign wpa_sat   = DIV_DEN_W'({wt_q, 4'b0000}) >= surf;

	// Pair arithmetic.
	assign dx      = abs_diff(rec_a_q.x, rec_b_q.x);
	assign dy      = abs_diff(rec_a_q.y, rec_b_q.y);
	assign dz      = abs_diff(rec_a_q.z, rec_b_q.z);
	assign d2      = SQ_IN_W'(dx2_q) + SQ_IN_W'(dy2_q) + SQ_IN_W'(dz2_q);
	assign ovl_hit = SQ_IN_W'(36'(ol_q) * 36'(ol_q)) >= d2;
	assign ra      = rec_a_q.rad;
	assign rb      = rec_b_q.rad;
	assign qneg    = rb < ra;
	assign mag     = {qneg ? (ra - rb) : (rb - ra), 16'h0000};
	assign qs      = qneg ? (27'd0 - 27'(qm_q)) : 27'(qm_q);
	assign term    = sel_q ? (27'(ONE_Q16) - qs) : (27'(ONE_Q16) + qs);
	assign term_pos = !term[26] && (term != '0);
	assign rec_sel  = sel_q ? rec_b_q : rec_a_q;
	assign frac_sel = sel_q ? fb_q : fa_q;

	always_comb begin
		case (op_q)
			OP_BONDED: fac = fbond_q;
			OP_ANGLE:  fac = fangle_q;
			OP_FAR:    fac = ffar_q;
			default:   fac = ffar_q;
		endcase
	end

	assign sh_sat    = |prod_q[73:36];
	assign c_val     = prod_q[35:20];
	assign sh_upd    = sh_sat || (c_val != '0);
	assign frac_prod = 34'(frac_sel) * 34'(ONE_Q16 - AREA_W'(c_val)) + 34'd32768;
	assign frac_new  = sh_sat ? '0 : frac_prod[32:16];
	assign frac_out  = sh_upd ? frac_new : frac_sel;

	// Memory writes.
	assign rec_we     = (state_q == S_LD_WR);
	assign area_we    = (state_q == S_LD_WR) || ((state_q == S_SH_WR) && sh_upd);
	assign area_waddr = (state_q == S_LD_WR) ? a_q : (sel_q ? b_q : a_q);
	assign area_wdata = (state_q == S_LD_WR) ? ONE_Q16 : frac_new;

	// Shared units.
	assign div_start = ((state_q == S_LD_SURF) && !wpa_sat) ||
		((state_q == S_QSET) && (d_q != '0));
	assign div_rem0  = (state_q == S_LD_SURF) ? DIV_DEN_W'({wt_q, 4'b0000}) : '0;
	assign div_num   = (state_q == S_LD_SURF) ? '0 : mag;
	assign div_den   = (state_q == S_LD_SURF) ? surf : DIV_DEN_W'(d_q);
	assign sq_start  = (state_q == S_SUM) && ovl_hit;

	sasa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.rem0   (div_rem0),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	sasa_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (d2),
		.done     (sq_done),
		.root     (sq_root)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			ov_q    <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (opcode == OP_LOAD) ? S_LD_MUL : S_RD_A;
					end
				end
				S_LD_MUL:  state_q <= S_LD_SURF;
				S_LD_SURF: state_q <= wpa_sat ? S_LD_WR : S_LD_DIV;
				S_LD_DIV: begin
					if (div_done) begin
						state_q <= S_LD_WR;
					end
				end
				S_LD_WR: begin
					ov_q    <= 1'b0;
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: state_q <= S_DIFF;
				S_DIFF: begin
					if (a_q == b_q) begin
						ov_q    <= 1'b0;
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (ovl_hit) begin
						state_q <= S_SQRT;
					end else begin
						ov_q    <= 1'b0;
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_QSET;
					end
				end
				S_QSET: begin
					sel_q   <= 1'b0;
					state_q <= (d_q == '0) ? S_SH_PM : S_QDIV;
				end
				S_QDIV: begin
					if (div_done) begin
						state_q <= S_SH_PM;
					end
				end
				S_SH_PM: begin
					if (term_pos) begin
						state_q <= S_SH_B;
					end else if (!sel_q) begin
						sel_q <= 1'b1;
					end else begin
						ov_q    <= 1'b1;
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SH_B:  state_q <= S_SH_PP;
				S_SH_PP: state_q <= S_SH_WR;
				S_SH_WR: begin
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= S_SH_PM;
					end else begin
						ov_q    <= 1'b1;
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q  <= opcode;
				a_q   <= atom_a;
				b_q   <= atom_b;
				x_q   <= coord_x;
				y_q   <= coord_y;
				z_q   <= coord_z;
				rad_q <= radius;
				wt_q  <= weight;
			end
			S_LD_MUL: begin
				s2_q  <= 34'(s_sum) * 34'(s_sum);
				spi_q <= 35'(s_sum) * 35'(PI_Q16);
			end
			S_LD_SURF: begin
				prs_q <= PRS_W'((36'(spi_q) + 36'd32768) >> 16);
				wpa_q <= '1;
			end
			S_LD_DIV: begin
				if (div_done) begin
					wpa_q <= div_quot;
				end
			end
			S_LD_WR: begin
				area_a_q <= ONE_Q16;
				area_b_q <= '0;
			end
			S_RD_A: begin
				rec_a_q <= rec_rd_q;
				fa_q    <= area_rd_q;
			end
			S_RD_B: begin
				rec_b_q <= rec_rd_q;
				fb_q    <= area_rd_q;
			end
			S_DIFF: begin
				dx2_q    <= 50'(dx) * 50'(dx);
				dy2_q    <= 50'(dy) * 50'(dy);
				dz2_q    <= 50'(dz) * 50'(dz);
				ol_q     <= 18'(ra) + 18'(rb) + 18'({probe_q, 1'b0});
				area_a_q <= fa_q;
				area_b_q <= fa_q;
			end
			S_SUM: begin
				area_a_q <= fa_q;
				area_b_q <= fb_q;
			end
			S_SQRT: begin
				d_q <= sq_root;
				m_q <= ol_q - 18'(sq_root);
			end
			S_QSET: begin
				qm_q <= (mag != '0) ? RATIO_SAT : '0;
			end
			S_QDIV: begin
				qm_q <= (div_quot > 32'(RATIO_SAT)) ? RATIO_SAT : div_quot[24:0];
			end
			S_SH_PM: begin
				term_q   <= term[24:0];
				pm_q     <= 31'((43'(rec_sel.prs) * 43'(m_q) + 43'd2048) >> 12);
				w_q      <= 33'((49'(rec_sel.wpa) * 49'(fac) + 49'd32768) >> 16);
				area_a_q <= fa_q;
				area_b_q <= fb_q;
			end
			S_SH_B: begin
				bv_q <= 40'((56'(pm_q) * 56'(term_q) + 56'd32768) >> 16);
			end
			S_SH_PP: begin
				prod_q <= 74'(51'(w_q) * 51'(bv_q[17:0])) +
					(74'(55'(w_q) * 55'(bv_q[39:18])) << 18);
			end
			S_SH_WR: begin
				if (sel_q) begin
					fb_q     <= frac_out;
					area_a_q <= fa_q;
					area_b_q <= frac_out;
				end else begin
					fa_q <= frac_out;
				end
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign valid      = valid_q;
	assign area_a     = area_a_q;
	assign area_b     = area_b_q;
	assign overlapped = ov_q;

`ifndef SYNTHESIS
	a_valid_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |=> !valid_q)
		else $error("result strobe held for more than one cycle");

	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> !busy)
		else $error("result strobe while an item is still in work");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_start && sq_start))
		else $error("divider and square root started together");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (op_q == OP_LOAD)) |-> (area_a_q == ONE_Q16) && !ov_q)
		else $error("load result does not report a full area fraction");
`endif

endmodule

// ===== dv/solvation_area_overlap_update_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Solvation area overlap update core testbench
// Loads atoms and pushes pair beats through the command port while the APB
// registers are set between phases. A predictor of the per-atom table computes
// the expected areas, unless a directed row gives known ones, and every result
// beat is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module solvation_area_overlap_update_core_tb;
	import sasa_pkg::*;

	typedef struct {
		logic [AREA_W-1:0] area_a;
		logic [AREA_W-1:0] area_b;
		logic              ovl;
	} area_beat_t;

	typedef struct {
		logic [1:0]       op;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] z;
		logic [RAD_W-1:0] r;
		logic [RAD_W-1:0] w;
		bit               typed;
		area_beat_t       known;
	} cmd_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic start, busy, valid, overlapped;
	logic [1:0] opcode;
	logic [IDX_W-1:0] atom_a, atom_b;
	logic signed [CRD_W-1:0] coord_x, coord_y, coord_z;
	logic [RAD_W-1:0] radius, weight;
	logic [AREA_W-1:0] area_a, area_b;

	solvation_area_overlap_update_core uut (.*);

	// Predicted table and registers.
	logic [CRD_W-1:0]  tab_x [ATOMS];
	logic [CRD_W-1:0]  tab_y [ATOMS];
	logic [CRD_W-1:0]  tab_z [ATOMS];
	logic [RAD_W-1:0]  tab_rad [ATOMS];
	logic [PRS_W-1:0]  tab_prs [ATOMS];
	logic [WPA_W-1:0]  tab_wpa [ATOMS];
	logic [AREA_W-1:0] tab_area [ATOMS];
	bit                tab_loaded [ATOMS];
	logic [PROBE_W-1:0] cfg_probe;
	logic [FAC_W-1:0]   cfg_fac [4];

	area_beat_t area_q[$];
	int errors = 0;
	longint cycles = 0;
	int burst_left = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		area_beat_t e;
		if (valid) begin
			if (area_q.size() == 0) report_mismatch("unexpected result beat", 1, 0);
			else begin
				e = area_q.pop_front();
				if (area_a !== e.area_a) report_mismatch("area_a", area_a, e.area_a);
				if (area_b !== e.area_b) report_mismatch("area_b", area_b, e.area_b);
				if (overlapped !== e.ovl) report_mismatch("overlapped", overlapped, e.ovl);
			end
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else res >>= 1;
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned coord_gap(logic [CRD_W-1:0] p, logic [CRD_W-1:0] q);
		longint d;
		d = longint'($signed(p)) - longint'($signed(q));
		return d < 0 ? -d : d;
	endfunction

	function automatic void shrink_area(int idx, longint tm, longint unsigned m,
		longint unsigned f);
		longint unsigned pm, bb, w, c;
		if (tm <= 0) return;
		pm = (longint'(tab_prs[idx]) * m + 2048) >> 12;
		bb = (pm * longint'(tm) + 32768) >> 16;
		w = (longint'(tab_wpa[idx]) * f + 32768) >> 16;
		if (w == 0 || bb == 0) return;
		if (bb > 64'hFFFF_FFFF_FFFF_FFFF / w) c = ONE_Q16;
		else c = (w * bb) >> 20;
		if (c == 0) return;
		if (c >= ONE_Q16) tab_area[idx] = 0;
		else tab_area[idx] = AREA_W'((longint'(tab_area[idx]) * (65536 - c) + 32768) >> 16);
	endfunction

	function automatic area_beat_t predict_areas(cmd_row_t c);
		area_beat_t res;
		longint unsigned s, surf, wpa, d2, ol, d, m, mag, qm, f;
		longint diff, q;
		res = '{0, 0, 0};
		if (c.op == OP_LOAD) begin
			s = longint'(c.r) + cfg_probe;
			surf = (s * s * FOURPI_Q16 + 32768) >> 16;
			if (surf == 0) wpa = 32'hFFFF_FFFF;
			else begin
				wpa = (longint'(c.w) << 36) / surf;
				if (wpa > 32'hFFFF_FFFF) wpa = 32'hFFFF_FFFF;
			end
			tab_x[c.a] = c.x;
			tab_y[c.a] = c.y;
			tab_z[c.a] = c.z;
			tab_rad[c.a] = c.r;
			tab_prs[c.a] = PRS_W'((s * PI_Q16 + 32768) >> 16);
			tab_wpa[c.a] = WPA_W'(wpa);
			tab_area[c.a] = ONE_Q16;
			tab_loaded[c.a] = 1;
			res.area_a = ONE_Q16;
			return res;
		end
		if (c.a != c.b) begin
			d2 = coord_gap(tab_x[c.a], tab_x[c.b]) ** 2 + coord_gap(tab_y[c.a], tab_y[c.b]) ** 2
				+ coord_gap(tab_z[c.a], tab_z[c.b]) ** 2;
			ol = longint'(tab_rad[c.a]) + tab_rad[c.b] + 2 * longint'(cfg_probe);
			if (ol * ol >= d2) begin
				d = int_sqrt(d2);
				m = ol - d;
				diff = longint'(tab_rad[c.b]) - longint'(tab_rad[c.a]);
				mag = (diff < 0 ? -diff : diff) << 16;
				if (d == 0) qm = mag != 0 ? RATIO_SAT : 0;
				else qm = mag / d;
				if (qm > RATIO_SAT) qm = RATIO_SAT;
				q = diff < 0 ? -longint'(qm) : longint'(qm);
				f = cfg_fac[c.op];
				res.ovl = 1;
				shrink_area(c.a, 65536 + q, m, f);
				shrink_area(c.b, 65536 - q, m, f);
			end
		end
		res.area_a = tab_area[c.a];
		res.area_b = tab_area[c.b];
		return res;
	endfunction

	task automatic issue_cmd(cmd_row_t c);
		area_beat_t e;
		opcode <= c.op;
		atom_a <= c.a;
		atom_b <= c.b;
		coord_x <= c.x;
		coord_y <= c.y;
		coord_z <= c.z;
		radius <= c.r;
		weight <= c.w;
		start <= 1;
		do @(posedge clk); while (busy);
		e = predict_areas(c);
		if (c.typed) e = c.known;
		area_q.insert(area_q.size(), e);
		if (burst_left > 0) burst_left--;
		else begin
			burst_left = $urandom_range(0, 20);
			start <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 0;
		while (area_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		@(posedge clk);
		if (idx == REG_PROBE) cfg_probe = val[PROBE_W-1:0];
		else cfg_fac[idx] = val[FAC_W-1:0];
	endtask

	task automatic set_regs(logic [PROBE_W-1:0] p, logic [FAC_W-1:0] fb,
		logic [FAC_W-1:0] fa, logic [FAC_W-1:0] ff);
		drain_results();
		write_reg(REG_PROBE, DATA_W'(p));
		write_reg(REG_FBOND, DATA_W'(fb));
		write_reg(REG_FANGLE, DATA_W'(fa));
		write_reg(REG_FFAR, DATA_W'(ff));
	endtask

	function automatic logic [CRD_W-1:0] pick_coord();
		if ($urandom_range(0, 99) < 12) return CRD_W'($urandom());
		return CRD_W'($signed($urandom_range(0, 30000)) - 15000);
	endfunction

	task automatic random_run(int n, ref int unsigned pool[32]);
		cmd_row_t c;
		int unsigned ia, ib;
		int loaded_cnt;
		for (int k = 0; k < n; k++) begin
			loaded_cnt = 0;
			foreach (pool[j]) if (tab_loaded[pool[j]]) loaded_cnt++;
			c = '{default: '0};
			c.op = 2'($urandom_range(1, 3));
			c.x = CRD_W'($urandom());
			c.y = CRD_W'($urandom());
			c.z = CRD_W'($urandom());
			c.r = RAD_W'($urandom());
			c.w = RAD_W'($urandom());
			c.b = IDX_W'($urandom());
			if (loaded_cnt < 2 || $urandom_range(0, 99) < 25) begin
				c.op = OP_LOAD;
				c.a = IDX_W'(pool[$urandom_range(0, 31)]);
				c.x = pick_coord();
				c.y = pick_coord();
				c.z = pick_coord();
				if ($urandom_range(0, 99) < 80) c.r = RAD_W'($urandom_range(3000, 9000));
				if ($urandom_range(0, 99) < 50) c.w = RAD_W'($urandom_range(0, 4096));
			end else begin
				do ia = pool[$urandom_range(0, 31)]; while (!tab_loaded[ia]);
				do ib = pool[$urandom_range(0, 31)]; while (!tab_loaded[ib]);
				if ($urandom_range(0, 99) < 3) ib = ia;
				c.a = IDX_W'(ia);
				c.b = IDX_W'(ib);
			end
			if (k == n / 2) drain_results();
			issue_cmd(c);
		end
	endtask

	cmd_row_t directed[$];

	initial begin
		int unsigned pool[32];
		arst_n = 0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		start <= 0;
		opcode <= OP_LOAD;
		atom_a <= '0;
		atom_b <= '0;
		coord_x <= '0;
		coord_y <= '0;
		coord_z <= '0;
		radius <= '0;
		weight <= '0;
		foreach (tab_loaded[i]) tab_loaded[i] = 0;
		cfg_probe = PROBE_RST;
		cfg_fac[OP_LOAD] = 0;
		cfg_fac[OP_BONDED] = FBOND_RST;
		cfg_fac[OP_ANGLE] = FANGLE_RST;
		cfg_fac[OP_FAR] = FFAR_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		directed = '{
			'{OP_LOAD, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 1,
				'{ONE_Q16, 0, 0}},
			'{OP_LOAD, 1023, 1023, 24'h800000, 24'h800000, 24'h800000, 0, 0, 1,
				'{ONE_Q16, 0, 0}},
			'{OP_BONDED, 0, 1023, 0, 0, 0, 0, 0, 1, '{ONE_Q16, ONE_Q16, 0}},
			'{OP_LOAD, 1, 0, 1000, -2000, 500, 6000, 4096, 1, '{ONE_Q16, 0, 0}},
			'{OP_LOAD, 2, 0, 1000, -2000, 500, 7000, 4096, 1, '{ONE_Q16, 0, 0}},
			'{OP_LOAD, 3, 0, 1000, -2000, 500, 6000, 2000, 1, '{ONE_Q16, 0, 0}},
			'{OP_LOAD, 4, 0, 9000, 3000, -4000, 5000, 0, 1, '{ONE_Q16, 0, 0}},
			'{OP_LOAD, 5, 0, 6000, 1000, 0, 8000, 12000, 1, '{ONE_Q16, 0, 0}},
			'{OP_FAR, 5, 5, 0, 0, 0, 0, 0, 1, '{ONE_Q16, ONE_Q16, 0}},
			'{OP_BONDED, 1, 2, 0, 0, 0, 0, 0, 0, '{0, 0, 0}},
			'{OP_ANGLE, 1, 3, 0, 0, 0, 0, 0, 0, '{0, 0, 0}},
			'{OP_FAR, 2, 4, 0, 0, 0, 0, 0, 0, '{0, 0, 0}},
			'{OP_BONDED, 3, 5, 0, 0, 0, 0, 0, 0, '{0, 0, 0}},
			'{OP_ANGLE, 4, 5, 0, 0, 0, 0, 0, 0, '{0, 0, 0}},
			'{OP_FAR, 5, 1, 0, 0, 0, 0, 0, 0, '{0, 0, 0}},
			'{OP_BONDED, 2, 1, 0, 0, 0, 0, 0, 0, '{0, 0, 0}},
			'{OP_LOAD, 6, 0, 0, 0, 0, 0, 65535, 1, '{ONE_Q16, 0, 0}},
			'{OP_BONDED, 6, 3, 0, 0, 0, 0, 0, 0, '{0, 0, 0}}
		};
		foreach (directed[i]) issue_cmd(directed[i]);

		pool[0] = 0;
		pool[1] = 1023;
		for (int j = 2; j < 32; j++) pool[j] = $urandom_range(0, ATOMS - 1);

		random_run(330, pool);
		set_regs(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_run(330, pool);
		set_regs(14'h3FFF, 0, 0, 0);
		random_run(330, pool);
		set_regs(PROBE_W'($urandom()), FAC_W'($urandom()), FAC_W'($urandom()),
			FAC_W'($urandom()));
		random_run(340, pool);

		drain_results();
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
